// File: rtl/sbda_pkg.sv
// Shared constants, types and helpers for the signed binary to decimal ASCII block.
// No dependencies; compile first.
package sbda_pkg;

  localparam int VALUE_BITS = 32;
  localparam int TEXT_W     = 6;
  localparam int STEP_BITS  = 8;

  function automatic int digit_count();
    logic [64:0] m;
    int          n;
    m = 65'd1 << (VALUE_BITS - 1);
    n = 0;
    for (int i = 0; i < 21; i++) begin
      if (m != '0) begin
        n = n + 1;
        m = m / 10;
      end
    end
    return n;
  endfunction

  localparam int DIGITS = digit_count();
  localparam int BCD_W  = 4 * DIGITS;
  localparam int NSTAGE = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int DAB_W  = NSTAGE * STEP_BITS;
  localparam int IDX_W  = $clog2(DIGITS);

  localparam logic [TEXT_W-1:0] CHAR_ZERO  = TEXT_W'(48);
  localparam logic [TEXT_W-1:0] CHAR_MINUS = TEXT_W'(45);

  typedef struct packed {
    logic             neg;
    logic [DAB_W-1:0] bin;
    logic [BCD_W-1:0] bcd;
  } sbda_work_t;

endpackage

// File: rtl/sbda_if.sv
// Channel interfaces: number words in, character words out.
// Depends on sbda_pkg.
interface sbda_in_if import sbda_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface sbda_out_if import sbda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_char;
  logic              last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// File: rtl/sbda_sign.sv
// Input stage: split sign from magnitude and seed the shift-add-3 work word.
// Depends on sbda_pkg and sbda_in_if.
module sbda_sign import sbda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbda_in_if.sink    num_i,
  output logic       valid_o,
  output sbda_work_t work_o,
  input  logic       ready_i
);

  logic                  valid_q;
  sbda_work_t            work_q, work_d;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;

  assign num_i.ready = !valid_q || ready_i;

  always_comb begin
    raw         = num_i.number;
    mag         = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
    work_d.neg  = raw[VALUE_BITS-1];
    work_d.bin  = DAB_W'(mag);
    work_d.bcd  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (num_i.ready) begin
      valid_q <= num_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (num_i.valid && num_i.ready) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// File: rtl/sbda_dabble_stage.sv
// One pipeline stage of the binary to BCD converter: a fixed number of shift-add-3 steps.
// Depends on sbda_pkg.
module sbda_dabble_stage import sbda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  sbda_work_t work_i,
  output logic       ready_o,
  output logic       valid_o,
  output sbda_work_t work_o,
  input  logic       ready_i
);

  logic       valid_q;
  sbda_work_t work_q, work_d;
  logic [BCD_W-1:0] b;
  logic [DAB_W-1:0] r;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    b = work_i.bcd;
    r = work_i.bin;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], r[DAB_W-1]};
      r = r << 1;
    end
    work_d.neg = work_i.neg;
    work_d.bin = r;
    work_d.bcd = b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

// File: rtl/sbda_serializer.sv
// Output stage: emit sign and significant BCD digits as ASCII, one word per cycle when ready.
// Depends on sbda_pkg and sbda_out_if.
module sbda_serializer import sbda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  sbda_work_t work_i,
  output logic       ready_o,
  sbda_out_if.source chr_o
);

  logic             busy_q;
  logic             neg_q;
  logic [IDX_W-1:0] idx_q;
  logic [BCD_W-1:0] bcd_q;
  logic [IDX_W-1:0] lead;
  logic [3:0]       digit;
  logic             fire;
  logic             done;

  always_comb begin
    lead = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (work_i.bcd[d*4 +: 4] != 4'd0) begin
        lead = IDX_W'(d);
      end
    end
  end

  assign digit           = bcd_q[idx_q*4 +: 4];
  assign chr_o.valid     = busy_q;
  assign chr_o.text_char = neg_q ? CHAR_MINUS : (CHAR_ZERO + TEXT_W'(digit));
  assign chr_o.last_char = !neg_q && (idx_q == '0);

  assign fire    = chr_o.valid && chr_o.ready;
  assign done    = fire && chr_o.last_char;
  assign ready_o = !busy_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      idx_q  <= '0;
    end else if (valid_i && ready_o) begin
      busy_q <= 1'b1;
      neg_q  <= work_i.neg;
      idx_q  <= lead;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      if (neg_q) begin
        neg_q <= 1'b0;
      end else begin
        idx_q <= idx_q - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      bcd_q <= work_i.bcd;
    end
  end

endmodule

// File: rtl/signed_binary_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, most significant character first.
// Depends on sbda_pkg, sbda_if, sbda_sign, sbda_dabble_stage, sbda_serializer.
//
//   channel  dir  payload                        word
//   num_i    in   number (32, signed)            one integer
//   chr_o    out  text_char (6), last_char (1)   one character, last_char on final one
//
// Accept to first character: sign, NSTAGE (4 at 32 bits) stage and serializer registers.
// The serializer sends one character per cycle while chr_o is ready, 1 to 11 characters
// per number; sign and four shift-add-3 stages take a word every cycle when not backed up.
// Reset clears all valid bits and the serializer state; payload registers are not reset.
// A stall on chr_o holds the serializer and backs up the stages; nothing is lost.
module signed_binary_to_decimal_ascii import sbda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbda_in_if.sink    num_i,
  sbda_out_if.source chr_o
);

  logic       valid  [NSTAGE+1];
  logic       ready  [NSTAGE+1];
  sbda_work_t work   [NSTAGE+1];

  sbda_sign u_sign (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .num_i   (num_i),
    .valid_o (valid[0]),
    .work_o  (work[0]),
    .ready_i (ready[0])
  );

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    sbda_dabble_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[g]),
      .work_i  (work[g]),
      .ready_o (ready[g]),
      .valid_o (valid[g+1]),
      .work_o  (work[g+1]),
      .ready_i (ready[g+1])
    );
  end

  sbda_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[NSTAGE]),
    .work_i  (work[NSTAGE]),
    .ready_o (ready[NSTAGE]),
    .chr_o   (chr_o)
  );

endmodule

// File: rtl/sbda_checker.sv
// Port-level checks on the character stream, bound to the top level.
// Depends on sbda_pkg and signed_binary_to_decimal_ascii.
module sbda_checker import sbda_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [TEXT_W-1:0] text_char_i,
  input logic              last_char_i
);

  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (text_char_i == CHAR_MINUS) ||
                    ((text_char_i >= CHAR_ZERO) && (text_char_i <= CHAR_ZERO + TEXT_W'(9))))
    else $error("character outside '-' and '0'..'9'");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (text_char_i == CHAR_MINUS)) |-> !last_char_i)
    else $error("minus sign ends a number");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_char_i) |=> out_valid_i)
    else $error("gap inside a number's text");

  a_after_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && (text_char_i == CHAR_MINUS)) |=>
      (text_char_i != CHAR_MINUS) && (text_char_i != CHAR_ZERO))
    else $error("minus sign followed by minus or leading zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      out_valid_i && $stable(text_char_i) && $stable(last_char_i))
    else $error("stalled word changed");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (chr_o.valid),
  .out_ready_i (chr_o.ready),
  .text_char_i (chr_o.text_char),
  .last_char_i (chr_o.last_char)
);
